### rtl/quantized_histogram_bayes_classifier_core_defines.svh
// Assertion macros shared by the classifier RTL.
`ifndef QUANTIZED_HISTOGRAM_BAYES_CLASSIFIER_CORE_DEFINES_SVH
`define QUANTIZED_HISTOGRAM_BAYES_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QHBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QHBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qhbc_pkg.sv
// Shared constants and operation codes of the histogram classifier.
package qhbc_pkg;

  localparam int FEATURES = 5;
  localparam int FEAT_W   = 16;
  localparam int COMP_W   = 3;
  localparam int BLVL_W   = 2;
  localparam int TALLY_W  = 24;
  localparam int CELL_W   = 10;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_TRAIN    = 2'd2,
    OP_CLASSIFY = 2'd3
  } op_t;

endpackage

### rtl/qhbc_req_if.sv
// Request channel: operation, bound load fields and one feature point.
interface qhbc_req_if;
  import qhbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [COMP_W-1:0] bound_component;
  logic [BLVL_W-1:0] bound_level;
  logic [FEAT_W-1:0] bound_value;
  logic [FEAT_W-1:0] feature_a;
  logic [FEAT_W-1:0] feature_b;
  logic [FEAT_W-1:0] feature_c;
  logic [FEAT_W-1:0] feature_d;
  logic [FEAT_W-1:0] feature_e;
  logic              true_label;

  modport source (
    output valid, op, bound_component, bound_level, bound_value,
           feature_a, feature_b, feature_c, feature_d, feature_e, true_label,
    input  ready
  );

  modport sink (
    input  valid, op, bound_component, bound_level, bound_value,
           feature_a, feature_b, feature_c, feature_d, feature_e, true_label,
    output ready
  );
endinterface

### rtl/qhbc_rsp_if.sv
// Result channel: decision, running tallies and the histogram cell.
interface qhbc_rsp_if;
  import qhbc_pkg::*;

  logic               valid;
  logic               ready;
  logic               decided_class;
  logic               was_correct;
  logic [TALLY_W-1:0] hits_total;
  logic [TALLY_W-1:0] tried_total;
  logic [CELL_W-1:0]  cell_address;

  modport source (
    output valid, decided_class, was_correct, hits_total, tried_total, cell_address,
    input  ready
  );

  modport sink (
    input  valid, decided_class, was_correct, hits_total, tried_total, cell_address,
    output ready
  );
endinterface

### rtl/quantized_histogram_bayes_classifier_core.sv
// Top level: two-class histogram classifier over quantized feature points.
// Train and classify requests read the histogram in the lookup state and post their result
// from the update state, where a train writes the count back; a load posts from lookup. A new
// request is taken only when idle, after the previous result is posted. A clear zeroes
// LEVELS**5 histogram rows, one per cycle, and the tallies, then posts its result. After reset
// the same sweep runs before the first request is taken; bounds and tallies reset to zero.
`include "quantized_histogram_bayes_classifier_core_defines.svh"

module quantized_histogram_bayes_classifier_core #(
  parameter int LEVELS     = 4,
  parameter int COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  qhbc_req_if.sink   req,
  qhbc_rsp_if.source rsp
);
  import qhbc_pkg::*;

  localparam int CELLS  = LEVELS ** FEATURES;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int WORD_W = 2 * COUNT_BITS;
  localparam logic [ADDR_W-1:0]  SWEEP_LAST = ADDR_W'(CELLS - 1);
  localparam logic [TALLY_W-1:0] TALLY_MAX  = '1;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_REPLY
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  sweep_idx;
  logic               sweep_reply;
  logic [TALLY_W-1:0] hit_counter;
  logic [TALLY_W-1:0] try_counter;
  logic [FEAT_W-1:0]  bounds [FEATURES][LEVELS-1];

  // Captured request.
  op_t               item_op;
  logic [COMP_W-1:0] item_comp;
  logic [BLVL_W-1:0] item_lvl;
  logic [FEAT_W-1:0] item_bval;
  logic [FEAT_W-1:0] item_feat [FEATURES];
  logic              item_label;
  logic [ADDR_W-1:0] hist_idx;

  // Output register.
  logic               out_valid;
  logic               out_decided;
  logic               out_correct;
  logic [TALLY_W-1:0] out_hits;
  logic [TALLY_W-1:0] out_tries;
  logic [CELL_W-1:0]  out_cell;

  logic                  slot_free;
  logic                  posting;
  logic [ADDR_W-1:0]     addr_q;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [COUNT_BITS-1:0] cnt_zero;
  logic [COUNT_BITS-1:0] cnt_one;
  logic [WORD_W-1:0]     trained_word;
  logic                  decided;
  logic                  correct;
  logic [TALLY_W-1:0]    hit_next;
  logic [TALLY_W-1:0]    try_next;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // A result is loaded into the output register in this cycle.
  assign posting = slot_free && ((state == S_LOOKUP && item_op == OP_LOAD) ||
                                 state == S_UPDATE || state == S_REPLY);

  // Cell address of the captured point.
  qhbc_quant #(.LEVELS(LEVELS)) u_quant (
    .features (item_feat),
    .bounds   (bounds),
    .addr     (addr_q)
  );

  // Both class counts of a cell share one word: class one in the upper half.
  qhbc_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_q),
    .rdata (ram_rdata)
  );

  // Count update and decision from the word read for this cell.
  always_comb begin
    cnt_zero = ram_rdata[COUNT_BITS-1:0];
    cnt_one  = ram_rdata[WORD_W-1:COUNT_BITS];
    trained_word = ram_rdata;
    if (item_label) begin
      if (!(&cnt_one)) begin
        trained_word[WORD_W-1:COUNT_BITS] = cnt_one + 1'b1;
      end
    end else begin
      if (!(&cnt_zero)) begin
        trained_word[COUNT_BITS-1:0] = cnt_zero + 1'b1;
      end
    end
    decided  = (cnt_zero < cnt_one);
    correct  = (decided == item_label);
    try_next = (try_counter != TALLY_MAX) ? try_counter + 1'b1 : try_counter;
    hit_next = (correct && hit_counter != TALLY_MAX) ? hit_counter + 1'b1 : hit_counter;
  end

  // Memory control: sweep writes zeros, train writes the updated word back.
  assign ram_re    = (state == S_LOOKUP) && (item_op == OP_TRAIN || item_op == OP_CLASSIFY);
  assign ram_we    = (state == S_SWEEP) ||
                     (state == S_UPDATE && slot_free && item_op == OP_TRAIN);
  assign ram_waddr = (state == S_SWEEP) ? sweep_idx : hist_idx;
  assign ram_wdata = (state == S_SWEEP) ? '0 : trained_word;

  // Sequencer with tallies, bounds and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_idx   <= '0;
      sweep_reply <= 1'b0;
      out_valid   <= 1'b0;
      hit_counter <= '0;
      try_counter <= '0;
      for (int f = 0; f < FEATURES; f++) begin
        for (int j = 0; j < LEVELS - 1; j++) begin
          bounds[f][j] <= '0;
        end
      end
    end else begin
      if (posting) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == SWEEP_LAST) begin
            state <= sweep_reply ? S_REPLY : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            item_op    <= op_t'(req.op);
            item_comp  <= req.bound_component;
            item_lvl   <= req.bound_level;
            item_bval  <= req.bound_value;
            item_feat[0] <= req.feature_a;
            item_feat[1] <= req.feature_b;
            item_feat[2] <= req.feature_c;
            item_feat[3] <= req.feature_d;
            item_feat[4] <= req.feature_e;
            item_label <= req.true_label;
            state      <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          case (item_op)
            OP_LOAD: begin
              if (slot_free) begin
                // A target outside the bound table matches no entry.
                for (int f = 0; f < FEATURES; f++) begin
                  for (int j = 0; j < LEVELS - 1; j++) begin
                    if (item_comp == COMP_W'(f) && int'(item_lvl) == j + 1) begin
                      bounds[f][j] <= item_bval;
                    end
                  end
                end
                out_decided <= 1'b0;
                out_correct <= 1'b0;
                out_hits    <= hit_counter;
                out_tries   <= try_counter;
                out_cell    <= '0;
                state       <= S_IDLE;
              end
            end
            OP_CLEAR: begin
              hit_counter <= '0;
              try_counter <= '0;
              sweep_idx   <= '0;
              sweep_reply <= 1'b1;
              state       <= S_SWEEP;
            end
            OP_TRAIN, OP_CLASSIFY: begin
              hist_idx <= addr_q;
              state    <= S_UPDATE;
            end
          endcase
        end
        S_UPDATE: begin
          if (slot_free) begin
            out_cell  <= CELL_W'(hist_idx);
            if (item_op == OP_CLASSIFY) begin
              hit_counter <= hit_next;
              try_counter <= try_next;
              out_decided <= decided;
              out_correct <= correct;
              out_hits    <= hit_next;
              out_tries   <= try_next;
            end else begin
              out_decided <= 1'b0;
              out_correct <= 1'b0;
              out_hits    <= hit_counter;
              out_tries   <= try_counter;
            end
            state <= S_IDLE;
          end
        end
        S_REPLY: begin
          if (slot_free) begin
            out_decided <= 1'b0;
            out_correct <= 1'b0;
            out_hits    <= hit_counter;
            out_tries   <= try_counter;
            out_cell    <= '0;
            sweep_reply <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.decided_class = out_decided;
  assign rsp.was_correct   = out_correct;
  assign rsp.hits_total    = out_hits;
  assign rsp.tried_total   = out_tries;
  assign rsp.cell_address  = out_cell;

  // Checks on the sequencer and the tallies.
  `QHBC_ASSERT_NOW(a_hits_le_tries, clk, rst, 1'b1, hit_counter <= try_counter,
                   "hit tally above try tally")
  `QHBC_ASSERT_NOW(a_no_write_idle, clk, rst, state == S_IDLE, !ram_we,
                   "histogram written while idle")
  `QHBC_ASSERT_NEXT(a_update_done, clk, rst, state == S_UPDATE && slot_free,
                    state == S_IDLE, "update did not finish when output was free")
  `QHBC_ASSERT_NEXT(a_sweep_step, clk, rst, state == S_SWEEP && sweep_idx != SWEEP_LAST,
                    state == S_SWEEP && sweep_idx == $past(sweep_idx) + 1'b1,
                    "clearing sweep skipped a row")

endmodule

### rtl/qhbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module qhbc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/qhbc_quant.sv
// Quantizes the five features against their level bounds into a cell address.
module qhbc_quant #(
  parameter int LEVELS  = 4,
  localparam int ADDR_W = $clog2(LEVELS ** qhbc_pkg::FEATURES),
  localparam int LVL_W  = $clog2(LEVELS)
) (
  input  logic [qhbc_pkg::FEAT_W-1:0] features [qhbc_pkg::FEATURES],
  input  logic [qhbc_pkg::FEAT_W-1:0] bounds [qhbc_pkg::FEATURES][LEVELS-1],
  output logic [ADDR_W-1:0]           addr
);
  import qhbc_pkg::*;

  // Each feature takes the last level whose bound it exceeds; levels are
  // weighted in mixed radix, first feature least significant.
  always_comb begin
    logic [LVL_W-1:0]  lvl;
    logic [ADDR_W-1:0] acc;
    acc = '0;
    for (int f = 0; f < FEATURES; f++) begin
      lvl = '0;
      for (int j = 1; j < LEVELS; j++) begin
        if (features[f] > bounds[f][j-1]) begin
          lvl = LVL_W'(j);
        end
      end
      acc = acc + ADDR_W'(ADDR_W'(lvl) * ADDR_W'(LEVELS ** f));
    end
    addr = acc;
  end

endmodule

### verif/qhbc_outcome_checker.sv
// Checker that predicts every classifier result and compares it with the design's output.
module qhbc_outcome_checker
  import qhbc_pkg::*;
#(
  parameter int LEVELS     = 4,
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  qhbc_req_if  req,
  qhbc_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = LEVELS - 1;
  localparam int CELLS = LEVELS ** FEATURES;
  localparam logic [TALLY_W-1:0]    TALLY_TOP = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  typedef logic [FEATURES-1:0][FEAT_W-1:0] point_t;

  typedef struct packed {
    logic               decided;
    logic               correct;
    logic [TALLY_W-1:0] hits;
    logic [TALLY_W-1:0] tried;
    logic [CELL_W-1:0]  hist_idx;
  } outcome_t;

  // Shadow copy of the classifier state.
  logic [FEAT_W-1:0]     bound_table [FEATURES*SLOTS];
  logic [COUNT_BITS-1:0] class0_count [CELLS];
  logic [COUNT_BITS-1:0] class1_count [CELLS];
  logic [TALLY_W-1:0]    hit_tally;
  logic [TALLY_W-1:0]    try_tally;
  outcome_t              awaited_outcomes [$];

  // Each feature lands on the highest level whose left bound it strictly exceeds.
  function automatic int unsigned point_cell(input point_t pt);
    int unsigned addr;
    int unsigned weight;
    int unsigned lvl;
    addr = 0;
    weight = 1;
    for (int f = 0; f < FEATURES; f++) begin
      lvl = 0;
      for (int j = 1; j < LEVELS; j++) begin
        if (pt[f] > bound_table[f*SLOTS + j - 1]) lvl = j;
      end
      addr += lvl * weight;
      weight *= LEVELS;
    end
    return addr % CELLS;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before new requests are predicted, since a result can
  // never belong to a request taken on the same edge.
  always @(posedge clk) begin : track
    point_t      pt;
    int unsigned hist_idx;
    outcome_t    nxt;
    outcome_t    want;
    if (rst) begin
      for (int k = 0; k < FEATURES*SLOTS; k++) bound_table[k] = '0;
      for (int c = 0; c < CELLS; c++) begin
        class0_count[c] = '0;
        class1_count[c] = '0;
      end
      hit_tally = '0;
      try_tally = '0;
      awaited_outcomes.delete();
    end else begin
      // Compare an accepted result with the oldest prediction.
      if (rsp.valid && rsp.ready) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual cell %0d",
                   $time, rsp.cell_address);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          compare_field("decided_class", 32'(want.decided), 32'(rsp.decided_class));
          compare_field("was_correct", 32'(want.correct), 32'(rsp.was_correct));
          compare_field("hits_total", 32'(want.hits), 32'(rsp.hits_total));
          compare_field("tried_total", 32'(want.tried), 32'(rsp.tried_total));
          compare_field("cell_address", 32'(want.hist_idx), 32'(rsp.cell_address));
        end
      end

      // Apply an accepted request to the shadow state and queue its result.
      if (req.valid && req.ready) begin
        pt  = {req.feature_e, req.feature_d, req.feature_c, req.feature_b, req.feature_a};
        nxt = '0;
        case (op_t'(req.op))
          OP_LOAD: begin
            if (req.bound_component < FEATURES && req.bound_level != 0 &&
                req.bound_level < LEVELS)
              bound_table[int'(req.bound_component)*SLOTS + int'(req.bound_level) - 1] =
                req.bound_value;
          end
          OP_CLEAR: begin
            for (int c = 0; c < CELLS; c++) begin
              class0_count[c] = '0;
              class1_count[c] = '0;
            end
            hit_tally = '0;
            try_tally = '0;
          end
          OP_TRAIN: begin
            hist_idx = point_cell(pt);
            if (req.true_label) begin
              if (class1_count[hist_idx] != COUNT_TOP) class1_count[hist_idx]++;
            end else begin
              if (class0_count[hist_idx] != COUNT_TOP) class0_count[hist_idx]++;
            end
            nxt.hist_idx = hist_idx[CELL_W-1:0];
          end
          OP_CLASSIFY: begin
            hist_idx = point_cell(pt);
            // Priors cancel, so raw counts decide; a tie goes to class 0.
            nxt.decided = (class0_count[hist_idx] < class1_count[hist_idx]);
            nxt.correct = (nxt.decided == req.true_label);
            if (try_tally != TALLY_TOP) try_tally++;
            if (nxt.correct && hit_tally != TALLY_TOP) hit_tally++;
            nxt.hist_idx = hist_idx[CELL_W-1:0];
          end
          default: ;
        endcase
        nxt.hits  = hit_tally;
        nxt.tried = try_tally;
        awaited_outcomes = {awaited_outcomes, nxt};
      end
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

### verif/tb.sv
// Testbench top: drives classifier requests, paces results and reports the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qhbc_pkg::*;

  localparam int LEVELS        = 4;
  // Narrow cell counts so that a hammered cell reaches its ceiling within the run.
  localparam int HIST_BITS     = 8;
  localparam int ITEM_TARGET   = 1700;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int HAMMER_LEN    = 270;
  localparam int POOL_SIZE     = 6;

  typedef logic [FEATURES-1:0][FEAT_W-1:0] point_t;

  logic        clk = 1'b0;
  logic        rst;
  int          mismatches;
  int          outstanding;
  int          sent = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;
  bit          hold_asked = 1'b0;
  bit          hold_done = 1'b0;
  bit          hammered = 1'b0;

  // Bounds as loaded so far, used only to aim features at level edges.
  logic [FEAT_W-1:0] shadow_bound [FEATURES][LEVELS-1];
  point_t            pool [POOL_SIZE];
  logic              pool_label [POOL_SIZE];

  qhbc_req_if req_ch ();
  qhbc_rsp_if rsp_ch ();

  quantized_histogram_bayes_classifier_core #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (HIST_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  qhbc_outcome_checker #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (HIST_BITS)
  ) outcome_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short idle spans, now and then a long one.
  function automatic int pace_len();
    return ($urandom_range(0, 6) == 0) ? int'($urandom_range(8, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  // Features sit on, just above or just below a loaded bound, at the extremes,
  // or anywhere.
  function automatic logic [FEAT_W-1:0] pick_feature(input int comp);
    logic [FEAT_W-1:0] b;
    b = shadow_bound[comp][$urandom_range(0, LEVELS-2)];
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return b;
      3:       return b + 16'd1;
      4:       return b - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic point_t fresh_point();
    point_t pt;
    for (int f = 0; f < FEATURES; f++) pt[f] = pick_feature(f);
    return pt;
  endfunction

  // Offer one request, hold it until it is taken, then maybe leave a gap.
  task automatic issue(input op_t op, input logic [COMP_W-1:0] comp,
                       input logic [BLVL_W-1:0] lvl, input logic [FEAT_W-1:0] bval,
                       input point_t pt, input logic label);
    int gap;
    req_ch.valid           <= 1'b1;
    req_ch.op              <= op;
    req_ch.bound_component <= comp;
    req_ch.bound_level     <= lvl;
    req_ch.bound_value     <= bval;
    req_ch.feature_a       <= pt[0];
    req_ch.feature_b       <= pt[1];
    req_ch.feature_c       <= pt[2];
    req_ch.feature_d       <= pt[3];
    req_ch.feature_e       <= pt[4];
    req_ch.true_label      <= label;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    if (op == OP_LOAD && comp < FEATURES && lvl != 0 && lvl < LEVELS)
      shadow_bound[comp][lvl-1] = bval;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pace_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Point operations carry random junk in the bound fields.
  task automatic issue_point(input op_t op, input point_t pt, input logic label);
    issue(op, 3'($urandom), 2'($urandom), 16'($urandom), pt, label);
  endtask

  task automatic issue_load(input logic [COMP_W-1:0] comp, input logic [BLVL_W-1:0] lvl,
                            input logic [FEAT_W-1:0] bval);
    issue(OP_LOAD, comp, lvl, bval, point_t'({$urandom, $urandom, $urandom}), 1'($urandom));
  endtask

  // Mostly legal bound targets, some out of range ones.
  task automatic random_load();
    logic [COMP_W-1:0] comp;
    logic [BLVL_W-1:0] lvl;
    logic [FEAT_W-1:0] val;
    if ($urandom_range(0, 4) == 0) begin
      comp = 3'($urandom);
      lvl  = 2'($urandom);
    end else begin
      comp = 3'($urandom_range(0, FEATURES-1));
      lvl  = 2'($urandom_range(1, LEVELS-1));
    end
    case ($urandom_range(0, 5))
      0:       val = '0;
      1:       val = '1;
      default: val = 16'($urandom);
    endcase
    issue_load(comp, lvl, val);
  endtask

  // Stop offering requests until every predicted result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side pacing, with one long hold-off that backs up the request side.
  initial begin : result_pacing
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_asked && !hold_done) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (pace_len()) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Request stimulus and verdict.
  initial begin : stimulus
    point_t      hot;
    logic        hot_label;
    int          idx;
    int unsigned pick;
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.op              <= OP_LOAD;
    req_ch.bound_component <= '0;
    req_ch.bound_level     <= '0;
    req_ch.bound_value     <= '0;
    req_ch.feature_a       <= '0;
    req_ch.feature_b       <= '0;
    req_ch.feature_c       <= '0;
    req_ch.feature_d       <= '0;
    req_ch.feature_e       <= '0;
    req_ch.true_label      <= 1'b0;
    for (int f = 0; f < FEATURES; f++)
      for (int j = 0; j < LEVELS-1; j++) shadow_bound[f][j] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty tables give a tie, which goes to class 0.
    issue_point(OP_CLASSIFY, '0, 1'b1);
    // With unset bounds any nonzero feature lands on the top level.
    issue_point(OP_TRAIN, '1, 1'b1);
    issue_point(OP_CLASSIFY, '1, 1'b1);
    issue_point(OP_TRAIN, '0, 1'b0);
    issue_point(OP_CLASSIFY, '0, 1'b0);
    // Equal counts in one cell.
    issue_point(OP_TRAIN, '1, 1'b0);
    issue_point(OP_CLASSIFY, '1, 1'b1);
    // Loads aimed at a missing component or at the fixed level 0 change nothing.
    issue_load(3'd5, 2'd1, 16'h1234);
    issue_load(3'd7, 2'd3, 16'hFFFF);
    issue_load(3'd2, 2'd0, 16'h0100);
    issue_load(3'd0, 2'd1, 16'h4000);
    issue_load(3'd0, 2'd2, 16'h8000);
    issue_load(3'd0, 2'd3, 16'hC000);
    issue_load(3'd4, 2'd3, 16'hFFFF);
    issue_load(3'd1, 2'd2, 16'h0001);
    // A feature equal to a bound does not pass it; one above does.
    issue_point(OP_TRAIN, {16'd1, 16'd1, 16'd1, 16'd1, 16'h4000}, 1'b1);
    issue_point(OP_CLASSIFY, {16'd1, 16'd1, 16'd1, 16'd1, 16'h4001}, 1'b1);
    issue_point(OP_CLASSIFY, {16'hFFFF, 16'd2, 16'd2, 16'd1, 16'hC001}, 1'b0);
    // Clear keeps the bounds and zeroes the tables and tallies.
    issue_point(OP_CLEAR, '1, 1'b1);
    issue_point(OP_CLASSIFY, {16'd1, 16'd1, 16'd1, 16'd1, 16'h4000}, 1'b0);
    drain();

    // Random segments: a pool of points is trained and classified repeatedly.
    while (sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) random_load();
      for (int p = 0; p < POOL_SIZE; p++) begin
        pool[p]       = fresh_point();
        pool_label[p] = 1'($urandom);
      end
      repeat ($urandom_range(20, 80)) begin
        pick = $urandom_range(0, 299);
        idx  = $urandom_range(0, POOL_SIZE-1);
        if (pick < 2)
          issue_point(OP_CLEAR, fresh_point(), 1'($urandom));
        else if (pick < 25)
          random_load();
        else if (pick < 160)
          issue_point(OP_TRAIN, pool[idx], pool_label[idx] ^ ($urandom_range(0, 4) == 0));
        else if (pick < 280)
          issue_point(OP_CLASSIFY, pool[idx], 1'($urandom));
        else
          issue_point(OP_CLASSIFY, fresh_point(), 1'($urandom));
        if (sent >= 500 && !hold_asked) hold_asked = 1'b1;
        if ($urandom_range(0, 249) == 0) drain();
      end

      // Once, drive one cell of one class into saturation.
      if (sent >= 900 && !hammered) begin
        hammered  = 1'b1;
        hot       = pool[0];
        hot_label = 1'($urandom);
        repeat (HAMMER_LEN) issue_point(OP_TRAIN, hot, hot_label);
        issue_point(OP_CLASSIFY, hot, hot_label);
        issue_point(OP_CLASSIFY, hot, !hot_label);
        repeat (20) issue_point(OP_TRAIN, hot, !hot_label);
        issue_point(OP_CLASSIFY, hot, hot_label);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### quantized_histogram_bayes_classifier_core.f
+incdir+rtl
rtl/qhbc_pkg.sv
rtl/qhbc_req_if.sv
rtl/qhbc_rsp_if.sv
rtl/qhbc_ram.sv
rtl/qhbc_quant.sv
rtl/quantized_histogram_bayes_classifier_core.sv
verif/qhbc_outcome_checker.sv
verif/tb.sv
